// ----- design/tile_sprite_pixel_renderer_defines.svh -----
// Assertion macros used by the renderer controller.
`ifndef TILE_SPRITE_PIXEL_RENDERER_DEFINES_SVH
`define TILE_SPRITE_PIXEL_RENDERER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TSPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define TSPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tspr_pkg.sv -----
// ----------------------------------------------------------------------------
// tspr_pkg
// Types and constants shared by the tile and sprite pixel renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tspr_pkg;

  // Input opcodes.
  typedef enum logic [1:0] {
    OP_VRAM_WR   = 2'd0,
    OP_SPRITE_WR = 2'd1,
    OP_PIXEL     = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_SPRITE_ENABLE = 3'd1;
  localparam logic [2:0] CFG_BG_MAP_HIGH   = 3'd2;
  localparam logic [2:0] CFG_TILE_UNSIGNED = 3'd3;
  localparam logic [2:0] CFG_TALL_SPRITES  = 3'd4;

  localparam logic [12:0] MAP_LOW_BASE  = 13'h1800;
  localparam logic [12:0] MAP_HIGH_BASE = 13'h1C00;
  localparam logic [12:0] SIGNED_BASE   = 13'h1000;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAP,
    ST_LO,
    ST_HI,
    ST_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // latch pixel coordinates, clear scan
    logic scan_step;   // examine one sprite entry
    logic rd_map;      // read tile map byte
    logic rd_lo;       // read low plane byte
    logic rd_hi;       // read high plane byte
    logic emit;        // present result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_last;   // current scan index is sprite 0
    logic hit;         // a covering sprite was found
  } status_t;

endpackage

// ----- design/tspr_datapath.sv -----
// ----------------------------------------------------------------------------
// tspr_datapath
// Video memory, sprite table, sprite scan and pixel shade assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tspr_datapath #(
  parameter int NumSprites   = 40,
  parameter int SpriteYShift = 16,
  parameter int SpriteXShift = 8,
  parameter int IdxW         = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic            cfg_data_i,
  input  logic            vram_we_i,
  input  logic [12:0]     vram_addr_i,
  input  logic [7:0]      vram_data_i,
  input  logic            spr_we_i,
  input  logic [5:0]      sprite_index_i,
  input  logic [7:0]      sprite_ypos_i,
  input  logic [7:0]      sprite_xpos_i,
  input  logic [7:0]      sprite_tile_i,
  input  logic            sprite_flip_h_i,
  input  logic            sprite_flip_v_i,
  input  logic [7:0]      pixel_x_i,
  input  logic [7:0]      pixel_y_i,
  input  tspr_pkg::cmd_t  cmd_i,
  output tspr_pkg::status_t status_o,
  output logic            sprite_en_o,
  output logic            bg_en_o,
  output logic            strobe_o,
  output logic [1:0]      shade_o,
  output logic            covered_o
);
  import tspr_pkg::*;

  // Configuration registers.
  logic bg_en_q, spr_en_q, map_high_q, tile_uns_q, tall_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_en_q <= 1'b0; spr_en_q <= 1'b0; map_high_q <= 1'b0;
      tile_uns_q <= 1'b0; tall_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BG_ENABLE:     bg_en_q    <= cfg_data_i;
        CFG_SPRITE_ENABLE: spr_en_q   <= cfg_data_i;
        CFG_BG_MAP_HIGH:   map_high_q <= cfg_data_i;
        CFG_TILE_UNSIGNED: tile_uns_q <= cfg_data_i;
        CFG_TALL_SPRITES:  tall_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign sprite_en_o = spr_en_q;
  assign bg_en_o     = bg_en_q;

  // Captured pixel and scan state.
  logic [7:0] px_q, py_q;
  logic [IdxW-1:0] scan_q;
  logic hit_q;
  logic [12:0] spr_row_q;
  logic [2:0] spr_bit_q;
  logic covers;
  logic scan_adv;

  // Sprite table: 26-bit entries with registered read data. The entry at
  // scan_q sits in the read register while it is examined.
  logic [25:0] spr_mem [NumSprites];
  logic [NumSprites-1:0] spr_valid_q;
  logic [25:0] spr_rdata_q;
  logic spr_rvalid_q;
  logic [IdxW-1:0] spr_raddr;
  logic spr_rd;

  // Fetch the top entry on capture, then the next lower one on each step without a hit.
  assign scan_adv  = cmd_i.scan_step && !hit_q && !covers && (scan_q != '0);
  assign spr_rd    = cmd_i.capture || scan_adv;
  assign spr_raddr = cmd_i.capture ? IdxW'(NumSprites - 1) : scan_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (spr_we_i && ({26'd0, sprite_index_i} < 32'(NumSprites))) begin
      spr_mem[sprite_index_i[IdxW-1:0]] <= {sprite_ypos_i, sprite_xpos_i,
        sprite_tile_i, sprite_flip_h_i, sprite_flip_v_i};
    end
    if (spr_rd) spr_rdata_q <= spr_mem[spr_raddr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_valid_q  <= '0;
      spr_rvalid_q <= 1'b0;
    end else begin
      if (spr_we_i && ({26'd0, sprite_index_i} < 32'(NumSprites))) begin
        spr_valid_q[sprite_index_i[IdxW-1:0]] <= 1'b1;
      end
      if (spr_rd) spr_rvalid_q <= spr_valid_q[spr_raddr];
    end
  end

  logic [25:0] ent;
  logic [7:0] e_y, e_x, e_t;
  logic e_fh, e_fv;
  logic signed [10:0] r, c;
  logic [3:0] dy;
  logic [2:0] dx;
  logic [7:0] tnum;

  always_comb begin
    ent = spr_rvalid_q ? spr_rdata_q : '0;
    {e_y, e_x, e_t, e_fh, e_fv} = ent;
    r = $signed({3'd0, py_q}) - ($signed({3'd0, e_y}) - 11'(SpriteYShift));
    c = $signed({3'd0, px_q}) - ($signed({3'd0, e_x}) - 11'(SpriteXShift));
    covers = (r >= 0) && (c >= 0) && (c < 11'sd8) &&
             (tall_q ? (r < 11'sd16) : (r < 11'sd8));
    dy = e_fv ? ((tall_q ? 4'd15 : 4'd7) - r[3:0]) : r[3:0];
    dx = e_fh ? (3'd7 - c[2:0]) : c[2:0];
    tnum = tall_q ? {e_t[7:1], 1'b0} : e_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      hit_q  <= 1'b0;
    end else if (cmd_i.capture) begin
      scan_q <= IdxW'(NumSprites - 1);
      hit_q  <= 1'b0;
    end else if (cmd_i.scan_step && !hit_q) begin
      if (covers) hit_q <= 1'b1;
      else if (scan_q != '0) scan_q <= scan_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (cmd_i.scan_step && !hit_q && covers) begin
      spr_row_q <= {1'b0, tnum, 4'd0} + {8'd0, dy, 1'b0};
      spr_bit_q <= 3'd7 - dx;
    end
  end

  assign status_o.scan_last = (scan_q == '0);
  assign status_o.hit       = hit_q;

  // Video memory: one write port and one read port, registered read data.
  logic [7:0] vram [8192];
  logic [7:0] rdata_q;
  logic [12:0] rd_addr;
  logic [12:0] bg_row_q;
  logic [12:0] bg_row_d;
  logic [12:0] map_addr;
  logic use_spr;

  assign use_spr  = spr_en_q && hit_q;
  assign map_addr = (map_high_q ? MAP_HIGH_BASE : MAP_LOW_BASE) +
                    {3'd0, py_q[7:3], px_q[7:3]};

  // Background row address from the map byte that the last cycle read.
  always_comb begin
    if (tile_uns_q) bg_row_d = {1'b0, rdata_q, 4'd0} + {9'd0, py_q[2:0], 1'b0};
    else bg_row_d = SIGNED_BASE + {{1{rdata_q[7]}}, rdata_q, 4'd0}
                    + {9'd0, py_q[2:0], 1'b0};
  end

  always_comb begin
    rd_addr = map_addr;
    if (cmd_i.rd_lo) rd_addr = use_spr ? spr_row_q : bg_row_d;
    else if (cmd_i.rd_hi) rd_addr = (use_spr ? spr_row_q : bg_row_q) | 13'd1;
  end

  always_ff @(posedge clk_i) begin
    if (vram_we_i) vram[vram_addr_i] <= vram_data_i;
    rdata_q <= vram[rd_addr];
  end

  // Plane bit capture behind the registered read data.
  logic map_pending_q, lo_pending_q;
  logic lo_bit_q;
  logic [2:0] bit_sel;
  assign bit_sel = use_spr ? spr_bit_q : (3'd7 - px_q[2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_pending_q <= 1'b0; lo_pending_q <= 1'b0;
    end else begin
      map_pending_q <= cmd_i.rd_map;
      lo_pending_q  <= cmd_i.rd_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_pending_q) bg_row_q <= bg_row_d;
    if (lo_pending_q) lo_bit_q <= rdata_q[bit_sel];
  end

  // Result register, shown for one cycle. The high plane byte arrives in
  // the emit cycle.
  logic strobe_q;
  logic [1:0] shade_q;
  logic covered_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_q <= 1'b0;
    else strobe_q <= cmd_i.emit;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (use_spr || bg_en_q) begin
        shade_q   <= {rdata_q[bit_sel], lo_bit_q};
        covered_q <= 1'b1;
      end else begin
        shade_q   <= 2'd0;
        covered_q <= 1'b0;
      end
    end
  end
  assign strobe_o  = strobe_q;
  assign shade_o   = shade_q;
  assign covered_o = covered_q;

endmodule

// ----- design/tspr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tspr_ctrl
// Sequencer for one pixel request: sprite scan, map and plane reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tile_sprite_pixel_renderer_defines.svh"
module tspr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic              bg_en_i,
  input  logic              sprite_en_i,
  input  tspr_pkg::status_t status_i,
  output tspr_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  import tspr_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (go_i) state_d = sprite_en_i ? ST_SCAN : ST_MAP;
      ST_SCAN: begin
        if (status_i.hit || status_i.scan_last) state_d = ST_MAP;
      end
      ST_MAP: begin
        if ((sprite_en_i && status_i.hit) || !bg_en_i) state_d = ST_LO;
        else state_d = ST_LO;
      end
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.capture = go_i;
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_MAP:  cmd_o.rd_map = 1'b1;
      ST_LO:   cmd_o.rd_lo = 1'b1;
      ST_HI:   cmd_o.rd_hi = 1'b1;
      ST_DONE: cmd_o.emit = 1'b1;
      default: ;
    endcase
  end

  `TSPR_ASSERT_IMP(a_emit_once, clk_i, rst_ni, cmd_o.emit, busy_o, "emit while idle")
  `TSPR_ASSERT_NEXT(a_hi_after_lo, clk_i, rst_ni, cmd_o.rd_lo, cmd_o.rd_hi, "plane order")
  `TSPR_ASSERT_NEXT(a_done_after_hi, clk_i, rst_ni, cmd_o.rd_hi, cmd_o.emit, "no emit")

endmodule

// ----- design/tile_sprite_pixel_renderer.sv -----
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer
// Tile map and sprite pixel renderer with 2-bit shades.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Memory and sprite
// writes finish in that cycle. A pixel request with sprites on first
// scans the sprite table one entry per cycle from the highest index; then
// the single video memory read port does the map, low plane and high plane
// reads. The result is shown on shade_o/covered_o for one cycle with
// valid_o and cannot be stalled. Video memory reads of unwritten bytes
// return unspecified data.
`timescale 1ns / 1ps
module tile_sprite_pixel_renderer #(
  parameter int NUM_SPRITES    = 40,
  parameter int SPRITE_Y_SHIFT = 16,
  parameter int SPRITE_X_SHIFT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [12:0] vram_addr_i,
  input  logic [7:0]  vram_data_i,
  input  logic [5:0]  sprite_index_i,
  input  logic [7:0]  sprite_ypos_i,
  input  logic [7:0]  sprite_xpos_i,
  input  logic [7:0]  sprite_tile_i,
  input  logic        sprite_flip_h_i,
  input  logic        sprite_flip_v_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        valid_o,
  output logic [1:0]  shade_o,
  output logic        covered_o
);
  import tspr_pkg::*;

  localparam int IdxW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

  cmd_t    cmd;
  status_t status;
  logic    acc, spr_en, bg_en;

  assign acc = start && !busy;

  tspr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .go_i        (acc && (opcode_i == OP_PIXEL)),
    .bg_en_i     (bg_en),
    .sprite_en_i (spr_en),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  tspr_datapath #(
    .NumSprites  (NUM_SPRITES),
    .SpriteYShift(SPRITE_Y_SHIFT),
    .SpriteXShift(SPRITE_X_SHIFT),
    .IdxW        (IdxW)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_index_i),
    .cfg_data_i      (cfg_data_i[0]),
    .vram_we_i       (acc && (opcode_i == OP_VRAM_WR)),
    .vram_addr_i, .vram_data_i,
    .spr_we_i        (acc && (opcode_i == OP_SPRITE_WR)),
    .sprite_index_i, .sprite_ypos_i, .sprite_xpos_i, .sprite_tile_i,
    .sprite_flip_h_i, .sprite_flip_v_i,
    .pixel_x_i, .pixel_y_i,
    .cmd_i       (cmd),
    .status_o    (status),
    .sprite_en_o (spr_en),
    .bg_en_o     (bg_en),
    .strobe_o    (valid_o),
    .shade_o, .covered_o
  );

endmodule
